// ----- rtl/phr_pkg.sv -----
// ----------------------------------------------------------------------------
// phr_pkg
// shared constants, codes and control structs of the probe health monitor
// ----------------------------------------------------------------------------
package phr_pkg;

  localparam int unsigned LATENCY_DEPTH = 64;
  localparam int unsigned BURST_CAP     = 6;

  localparam int unsigned FILL_W  = $clog2(LATENCY_DEPTH + 1);
  localparam int unsigned ADDR_W  = $clog2(LATENCY_DEPTH);
  localparam int unsigned BURST_W = $clog2(BURST_CAP + 1);

  // opcodes
  localparam logic [1:0] OP_PROBE  = 2'd0;
  localparam logic [1:0] OP_ROLLUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_COUNTED = 3'd0;
  localparam logic [2:0] KIND_ALERT   = 3'd1;
  localparam logic [2:0] KIND_REPORT  = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;

  // health codes
  localparam logic [1:0] H_UNKNOWN = 2'd0;
  localparam logic [1:0] H_DOWN    = 2'd1;
  localparam logic [1:0] H_UP      = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FAIL_TH = 2'd0;
  localparam logic [1:0] REG_OK_TH   = 2'd1;
  localparam logic [1:0] REG_LAT_LIM = 2'd2;
  localparam logic [1:0] REG_DNS_EN  = 2'd3;

  typedef struct packed {
    logic [7:0]  fail_threshold;
    logic [7:0]  ok_threshold;
    logic [15:0] latency_limit_ms;
    logic        dns_check_enable;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic cand_rd;
    logic cand_latch;
    logic cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep;
    logic cmp_last;
    logic cand_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/probe_health_hysteresis_rollup_top.sv -----
// ----------------------------------------------------------------------------
// probe_health_hysteresis_rollup_top
// health monitor for one target: up/down hysteresis, quick re-probe bursts
// and a rollup of counts and p50/p95 latency
// ----------------------------------------------------------------------------
//
//   channel   handshake                     carries
//   -------   ---------------------------   ---------------------------------
//   input     in_valid_i / in_ready_o       opcode and probe result fields
//   result    out_valid_o / out_ready_i     kind, health, streak, rollup data
//   config    psel, penable, pwrite, pready thresholds, latency limit, dns
//
// - probe, run reset, unused opcodes, empty rollup and a rollup with no stored
//   latency: execute, then hand-off, which registers the result; the next one
//   is taken only once the block is back in idle
// - rollup with n stored latencies: each entry is latched as candidate and
//   ranked against every other through the single read port of the store
// - one transaction is in flight at a time; a waiting result holds the block
//   in its hand-off state until the result side takes it
// - the latency store needs no clearing after reset, only entries below the
//   fill count are ever used
//
module probe_health_hysteresis_rollup_top import phr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic        probe_passed_i,
  input  logic        answer_matched_i,
  input  logic [19:0] rtt_sixteenths_i,
  input  logic        was_deferred_i,
  input  logic        target_blocked_i,

  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [1:0]  health_state_o,
  output logic [7:0]  fail_streak_o,
  output logic        blocked_flag_o,
  output logic [19:0] last_rtt_o,
  output logic        quick_reprobe_o,
  output logic [15:0] ok_total_o,
  output logic [15:0] fail_total_o,
  output logic [15:0] median_ms_o,
  output logic [15:0] p95_ms_o,
  output logic [16:0] sample_total_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file, to be written only while no transaction is in flight; the block does not enforce this
  phr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  phr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, hysteresis, latency store and percentile sweep
  phr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .probe_passed_i   (probe_passed_i),
    .answer_matched_i (answer_matched_i),
    .rtt_sixteenths_i (rtt_sixteenths_i),
    .was_deferred_i   (was_deferred_i),
    .target_blocked_i (target_blocked_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .result_kind_o    (result_kind_o),
    .health_state_o   (health_state_o),
    .fail_streak_o    (fail_streak_o),
    .blocked_flag_o   (blocked_flag_o),
    .last_rtt_o       (last_rtt_o),
    .quick_reprobe_o  (quick_reprobe_o),
    .ok_total_o       (ok_total_o),
    .fail_total_o     (fail_total_o),
    .median_ms_o      (median_ms_o),
    .p95_ms_o         (p95_ms_o),
    .sample_total_o   (sample_total_o)
  );

endmodule

// ----- rtl/phr_ram.sv -----
// ----------------------------------------------------------------------------
// phr_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module phr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/phr_regs.sv -----
// ----------------------------------------------------------------------------
// phr_regs
// apb configuration registers: thresholds, latency limit, dns check
// ----------------------------------------------------------------------------
module phr_regs import phr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_threshold   <= 8'd3;
      cfg_q.ok_threshold     <= 8'd2;
      cfg_q.latency_limit_ms <= 16'd0;
      cfg_q.dns_check_enable <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_FAIL_TH: cfg_q.fail_threshold   <= pwdata[7:0];
        REG_OK_TH:   cfg_q.ok_threshold     <= pwdata[7:0];
        REG_LAT_LIM: cfg_q.latency_limit_ms <= pwdata[15:0];
        REG_DNS_EN:  cfg_q.dns_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAIL_TH: prdata = {24'd0, cfg_q.fail_threshold};
      REG_OK_TH:   prdata = {24'd0, cfg_q.ok_threshold};
      REG_LAT_LIM: prdata = {16'd0, cfg_q.latency_limit_ms};
      REG_DNS_EN:  prdata = {31'd0, cfg_q.dns_check_enable};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/phr_ctrl.sv -----
// ----------------------------------------------------------------------------
// phr_ctrl
// sequencer: capture, execute, percentile sweep, result hand-off
// ----------------------------------------------------------------------------
module phr_ctrl import phr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_CAND = 3'd2;
  localparam logic [2:0] ST_CLAT = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.sweep ? ST_CAND : ST_OUT;
      end
      ST_CAND: begin
        cmd_o.cand_rd = 1'b1;
        state_d       = ST_CLAT;
      end
      ST_CLAT: begin
        cmd_o.cand_latch = 1'b1;
        state_d          = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.cmp_last) begin
          state_d = sts_i.cand_last ? ST_OUT : ST_CAND;
        end
      end
      ST_OUT: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/phr_dp.sv -----
// ----------------------------------------------------------------------------
// phr_dp
// datapath: hysteresis and counters, latency store, rank sweep, result register
// ----------------------------------------------------------------------------
module phr_dp import phr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  input  logic [1:0]   opcode_i,
  input  logic         probe_passed_i,
  input  logic         answer_matched_i,
  input  logic [19:0]  rtt_sixteenths_i,
  input  logic         was_deferred_i,
  input  logic         target_blocked_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [2:0]   result_kind_o,
  output logic [1:0]   health_state_o,
  output logic [7:0]   fail_streak_o,
  output logic         blocked_flag_o,
  output logic [19:0]  last_rtt_o,
  output logic         quick_reprobe_o,
  output logic [15:0]  ok_total_o,
  output logic [15:0]  fail_total_o,
  output logic [15:0]  median_ms_o,
  output logic [15:0]  p95_ms_o,
  output logic [16:0]  sample_total_o
);

  localparam int unsigned PROD_W = FILL_W + 19;
  localparam logic [15:0] RECIP5 = 16'd52429; // ceil(2^18 / 5)

  // captured transaction
  logic [1:0]  op_q;
  logic        pass_q, match_q, defer_q, blk_q;
  logic [19:0] rtt_q;

  // run state
  logic [1:0]         health_q;
  logic [7:0]         fail_run_q, ok_run_q;
  logic [15:0]        ok_b_q, fail_b_q;
  logic [FILL_W-1:0]  fill_q;
  logic [BURST_W-1:0] burst_q;
  logic [19:0]        recent_rtt_q;
  logic               recent_blk_q;

  // result staging
  logic [2:0]  kind_q;
  logic        quick_q;
  logic [15:0] r_ok_q, r_fail_q, r_p50_q, r_p95_q;
  logic [16:0] r_total_q;

  // rank sweep
  logic [FILL_W-1:0] n_q, k50_q, k95_q, lt_q, le_q, lt_f, le_f;
  logic [ADDR_W-1:0] c_q, j_q, raddr;
  logic [15:0]       cand_q, rdata;

  // output register
  logic        out_valid_q;

  // probe evaluation
  logic [7:0]         fth, oth, ok_run_n, fail_run_n;
  logic               lim_ok, is_ok, mid, quick_n;
  logic [1:0]         health_n;
  logic [2:0]         kind_probe;
  logic [BURST_W-1:0] burst_n;
  logic [20:0]        rtt_rnd;
  logic [15:0]        ms;
  logic [16:0]        bucket_sum;
  logic               store_we;

  // p95 rank
  logic [FILL_W+4:0] n19;
  logic [FILL_W+2:0] n19_q4;
  logic [PROD_W-1:0] prod;
  logic [FILL_W-1:0] k95_raw, k95_n;

  always_comb begin
    fth = (cfg_i.fail_threshold == 8'd0) ? 8'd1 : cfg_i.fail_threshold;
    oth = (cfg_i.ok_threshold == 8'd0) ? 8'd1 : cfg_i.ok_threshold;

    lim_ok = (cfg_i.latency_limit_ms == 16'd0) ||
             (rtt_q <= {cfg_i.latency_limit_ms, 4'b0000});
    is_ok  = pass_q && (!cfg_i.dns_check_enable || match_q) && lim_ok;

    if (is_ok) begin
      ok_run_n   = (ok_run_q == 8'hFF) ? ok_run_q : ok_run_q + 8'd1;
      fail_run_n = 8'd0;
    end else begin
      ok_run_n   = 8'd0;
      fail_run_n = (fail_run_q == 8'hFF) ? fail_run_q : fail_run_q + 8'd1;
    end

    health_n   = health_q;
    kind_probe = KIND_COUNTED;
    if (health_q != H_DOWN && fail_run_n >= fth) begin
      health_n   = H_DOWN;
      kind_probe = KIND_ALERT;
    end else if (health_q != H_UP && ok_run_n >= oth) begin
      health_n   = H_UP;
      kind_probe = KIND_ALERT;
    end

    mid = (health_n != H_DOWN && fail_run_n != 8'd0 && fail_run_n < fth) ||
          (health_n != H_UP && ok_run_n != 8'd0 && ok_run_n < oth);
    if (mid && burst_q < BURST_W'(BURST_CAP)) begin
      burst_n = burst_q + BURST_W'(1);
      quick_n = 1'b1;
    end else begin
      burst_n = '0;
      quick_n = 1'b0;
    end

    // round half up to whole ms, saturate
    rtt_rnd = {1'b0, rtt_q} + 21'd8;
    ms      = rtt_rnd[20] ? 16'hFFFF : rtt_rnd[19:4];

    bucket_sum = {1'b0, ok_b_q} + {1'b0, fail_b_q};
    store_we   = cmd_i.exec && (op_q == OP_PROBE) && !defer_q && is_ok &&
                 (fill_q < FILL_W'(LATENCY_DEPTH));

    // floor(n*95/100) = floor(floor(19n/4)/5)
    n19     = {1'b0, fill_q, 4'b0000} + {4'b0000, fill_q, 1'b0} + {5'b00000, fill_q};
    n19_q4  = n19[FILL_W+4:2];
    prod    = PROD_W'(n19_q4) * PROD_W'(RECIP5);
    k95_raw = prod[18 +: FILL_W];
    k95_n   = (k95_raw >= fill_q) ? fill_q - FILL_W'(1) : k95_raw;
  end

  assign sts_o.sweep     = (op_q == OP_ROLLUP) && (bucket_sum != 17'd0) &&
                           (fill_q != '0);
  assign sts_o.cmp_last  = (FILL_W'(j_q) == n_q - FILL_W'(1));
  assign sts_o.cand_last = (FILL_W'(c_q) == n_q - FILL_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // latency store
  always_comb begin
    if (cmd_i.cand_rd) begin
      raddr = c_q;
    end else if (cmd_i.cand_latch) begin
      raddr = '0;
    end else begin
      raddr = j_q + ADDR_W'(1);
    end
  end

  phr_ram #(
    .WIDTH (16),
    .DEPTH (LATENCY_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (ms),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // counts including the entry on the read port
  assign lt_f = lt_q + FILL_W'(rdata < cand_q);
  assign le_f = le_q + FILL_W'(rdata <= cand_q);

  // capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      pass_q  <= probe_passed_i;
      match_q <= answer_matched_i;
      rtt_q   <= rtt_sixteenths_i;
      defer_q <= was_deferred_i;
      blk_q   <= target_blocked_i;
    end
  end

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      health_q     <= H_UNKNOWN;
      fail_run_q   <= 8'd0;
      ok_run_q     <= 8'd0;
      ok_b_q       <= 16'd0;
      fail_b_q     <= 16'd0;
      fill_q       <= '0;
      burst_q      <= '0;
      recent_rtt_q <= 20'd0;
      recent_blk_q <= 1'b0;
    end else if (cmd_i.exec) begin
      case (op_q)
        OP_PROBE: begin
          if (!defer_q) begin
            health_q     <= health_n;
            fail_run_q   <= fail_run_n;
            ok_run_q     <= ok_run_n;
            burst_q      <= burst_n;
            recent_rtt_q <= rtt_q;
            recent_blk_q <= blk_q;
            if (is_ok) begin
              if (ok_b_q != 16'hFFFF) begin
                ok_b_q <= ok_b_q + 16'd1;
              end
            end else if (fail_b_q != 16'hFFFF) begin
              fail_b_q <= fail_b_q + 16'd1;
            end
            if (store_we) begin
              fill_q <= fill_q + FILL_W'(1);
            end
          end
        end
        OP_ROLLUP: begin
          // the sweep reads from n_q, so the fill count clears at once
          if (bucket_sum != 17'd0) begin
            ok_b_q   <= 16'd0;
            fail_b_q <= 16'd0;
            fill_q   <= '0;
          end
        end
        OP_CLEAR: begin
          health_q     <= H_UNKNOWN;
          fail_run_q   <= 8'd0;
          ok_run_q     <= 8'd0;
          ok_b_q       <= 16'd0;
          fail_b_q     <= 16'd0;
          fill_q       <= '0;
          burst_q      <= '0;
          recent_rtt_q <= 20'd0;
          recent_blk_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result staging and rank sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      quick_q   <= 1'b0;
      r_ok_q    <= 16'd0;
      r_fail_q  <= 16'd0;
      r_total_q <= 17'd0;
      r_p50_q   <= 16'd0;
      r_p95_q   <= 16'd0;
      n_q       <= fill_q;
      k50_q     <= fill_q >> 1;
      k95_q     <= k95_n;
      c_q       <= '0;
      case (op_q)
        OP_PROBE: begin
          if (defer_q) begin
            kind_q <= KIND_IGNORED;
          end else begin
            kind_q  <= kind_probe;
            quick_q <= quick_n;
          end
        end
        OP_ROLLUP: begin
          if (bucket_sum == 17'd0) begin
            kind_q <= KIND_EMPTY;
          end else begin
            kind_q    <= KIND_REPORT;
            r_ok_q    <= ok_b_q;
            r_fail_q  <= fail_b_q;
            r_total_q <= bucket_sum;
          end
        end
        OP_CLEAR: kind_q <= KIND_COUNTED;
        default:  kind_q <= KIND_IGNORED;
      endcase
    end

    if (cmd_i.cand_latch) begin
      cand_q <= rdata;
      j_q    <= '0;
      lt_q   <= '0;
      le_q   <= '0;
    end

    if (cmd_i.cmp) begin
      j_q  <= j_q + ADDR_W'(1);
      lt_q <= lt_f;
      le_q <= le_f;
      if (sts_o.cmp_last) begin
        // candidate holds rank k when lt <= k < le
        if (lt_f <= k50_q && k50_q < le_f) begin
          r_p50_q <= cand_q;
        end
        if (lt_f <= k95_q && k95_q < le_f) begin
          r_p95_q <= cand_q;
        end
        if (!sts_o.cand_last) begin
          c_q <= c_q + ADDR_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_kind_o   <= kind_q;
      health_state_o  <= health_q;
      fail_streak_o   <= fail_run_q;
      blocked_flag_o  <= (health_q == H_DOWN) && recent_blk_q;
      last_rtt_o      <= recent_rtt_q;
      quick_reprobe_o <= quick_q;
      ok_total_o      <= r_ok_q;
      fail_total_o    <= r_fail_q;
      median_ms_o     <= r_p50_q;
      p95_ms_o        <= r_p95_q;
      sample_total_o  <= r_total_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the probe health monitor: directed transactions, some
// with typed results, then randomised phases under several register settings,
// the rest checked against a behavioural predictor of hysteresis, bursts and rollups
// ----------------------------------------------------------------------------
module tb;
  import phr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // generous bound on the whole run, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 500000;
  // opcode 3 has no meaning and must be dropped by the block
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  // one input transaction
  typedef struct packed {
    logic [1:0]  op;
    logic        passed;
    logic        matched;
    logic [19:0] rtt;
    logic        deferred;
    logic        blocked;
  } probe_txn_t;

  // one result transaction, fields in port order
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  health;
    logic [7:0]  streak;
    logic        blocked;
    logic [19:0] last_rtt;
    logic        quick;
    logic [15:0] ok_total;
    logic [15:0] fail_total;
    logic [15:0] median;
    logic [15:0] p95;
    logic [16:0] sample_total;
  } health_res_t;

  // a directed row carries its expectation only where it is obvious
  typedef struct {
    probe_txn_t  txn;
    bit          typed;
    health_res_t res;
  } dir_row_t;

  // ports of the block
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [3:0]  paddr            = '0;
  logic [31:0] pwdata           = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i         = OP_PROBE;
  logic        probe_passed_i   = 1'b0;
  logic        answer_matched_i = 1'b0;
  logic [19:0] rtt_sixteenths_i = '0;
  logic        was_deferred_i   = 1'b0;
  logic        target_blocked_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [2:0]  result_kind_o;
  logic [1:0]  health_state_o;
  logic [7:0]  fail_streak_o;
  logic        blocked_flag_o;
  logic [19:0] last_rtt_o;
  logic        quick_reprobe_o;
  logic [15:0] ok_total_o;
  logic [15:0] fail_total_o;
  logic [15:0] median_ms_o;
  logic [15:0] p95_ms_o;
  logic [16:0] sample_total_o;

  // bench bookkeeping
  health_res_t pending_res [$];   // results still owed by the block, oldest first
  dir_row_t    dir_rows [$];
  int unsigned cycles = 0;
  int          errs   = 0;
  bit          steady = 1'b0;     // when set neither side idles

  // predictor copy of the registers and of the monitor state
  cfg_t        cfg;
  logic [1:0]  mon_health;
  logic [7:0]  mon_fail_run;
  logic [7:0]  mon_ok_run;
  logic [15:0] mon_ok_bkt;
  logic [15:0] mon_fail_bkt;
  logic [15:0] mon_lat [LATENCY_DEPTH];
  int unsigned mon_fill;
  int unsigned mon_burst;
  logic [19:0] mon_rtt;
  logic        mon_blk;

  probe_health_hysteresis_rollup_top dut (.*);

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL probe_health_hysteresis_rollup_top");
      $finish;
    end
  end

  // result side back-pressure, stalled about 35 percent of the time unless steady is set
  always @(negedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // run state back to its reset values, registers untouched
  function automatic void clear_monitor();
    mon_health   = H_UNKNOWN;
    mon_fail_run = '0;
    mon_ok_run   = '0;
    mon_ok_bkt   = '0;
    mon_fail_bkt = '0;
    mon_fill     = 0;
    mon_burst    = 0;
    mon_rtt      = '0;
    mon_blk      = 1'b0;
  endfunction

  // advances the predictor by one accepted transaction and returns its result
  function automatic health_res_t advance_monitor(probe_txn_t t);
    health_res_t r;
    logic [15:0] srt [LATENCY_DEPTH];
    logic [15:0] v;
    int unsigned n, i, j, i95, fth, oth, ms;
    bit ok, mid;
    r      = '0;
    r.kind = KIND_IGNORED;
    // a zero threshold behaves as one
    fth = (cfg.fail_threshold == 0) ? 1 : cfg.fail_threshold;
    oth = (cfg.ok_threshold == 0) ? 1 : cfg.ok_threshold;
    if (t.op == OP_PROBE && !t.deferred) begin
      ok = t.passed && (!cfg.dns_check_enable || t.matched) &&
           (cfg.latency_limit_ms == 0 || t.rtt <= {cfg.latency_limit_ms, 4'h0});
      mon_rtt = t.rtt;
      mon_blk = t.blocked;
      if (ok) begin
        if (mon_ok_bkt != 16'hFFFF) mon_ok_bkt++;
        if (mon_fill < LATENCY_DEPTH) begin
          // whole ms rounded half up, saturated to 16 bits
          ms = (t.rtt + 8) >> 4;
          if (ms > 65535) ms = 65535;
          mon_lat[mon_fill] = ms[15:0];
          mon_fill++;
        end
        if (mon_ok_run != 8'hFF) mon_ok_run++;
        mon_fail_run = '0;
      end else begin
        if (mon_fail_bkt != 16'hFFFF) mon_fail_bkt++;
        if (mon_fail_run != 8'hFF) mon_fail_run++;
        mon_ok_run = '0;
      end
      r.kind = KIND_COUNTED;
      if (mon_health != H_DOWN && mon_fail_run >= fth) begin
        mon_health = H_DOWN;
        r.kind     = KIND_ALERT;
      end else if (mon_health != H_UP && mon_ok_run >= oth) begin
        mon_health = H_UP;
        r.kind     = KIND_ALERT;
      end
      mid = (mon_health != H_DOWN && mon_fail_run > 0 && mon_fail_run < fth) ||
            (mon_health != H_UP && mon_ok_run > 0 && mon_ok_run < oth);
      if (mid && mon_burst < BURST_CAP) begin
        mon_burst++;
        r.quick = 1'b1;
      end else begin
        mon_burst = 0;
      end
    end else if (t.op == OP_ROLLUP) begin
      if (mon_ok_bkt == 0 && mon_fail_bkt == 0) begin
        r.kind = KIND_EMPTY;
      end else begin
        r.kind         = KIND_REPORT;
        r.ok_total     = mon_ok_bkt;
        r.fail_total   = mon_fail_bkt;
        r.sample_total = 17'(mon_ok_bkt) + 17'(mon_fail_bkt);
        n = mon_fill;
        if (n > 0) begin
          for (i = 0; i < n; i++) srt[i] = mon_lat[i];
          for (i = 1; i < n; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j - 1] > v) begin
              srt[j] = srt[j - 1];
              j--;
            end
            srt[j] = v;
          end
          i95 = n * 95 / 100;
          if (i95 >= n) i95 = n - 1;
          r.median = srt[n / 2];
          r.p95    = srt[i95];
        end
        mon_ok_bkt   = '0;
        mon_fail_bkt = '0;
        mon_fill     = 0;
      end
    end else if (t.op == OP_CLEAR) begin
      clear_monitor();
      r.kind = KIND_COUNTED;
    end
    r.health   = mon_health;
    r.streak   = mon_fail_run;
    r.blocked  = (mon_health == H_DOWN) && mon_blk;
    r.last_rtt = mon_rtt;
    return r;
  endfunction

  function automatic string fmt_res(health_res_t r);
    return $sformatf({"kind %0d health %0d streak %0d blk %0b rtt 0x%05h quick %0b",
                      " ok %0d fail %0d p50 %0d p95 %0d n %0d"},
                     r.kind, r.health, r.streak, r.blocked, r.last_rtt, r.quick,
                     r.ok_total, r.fail_total, r.median, r.p95, r.sample_total);
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    health_res_t got;
    health_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {result_kind_o, health_state_o, fail_streak_o, blocked_flag_o, last_rtt_o,
             quick_reprobe_o, ok_total_o, fail_total_o, median_ms_o, p95_ms_o,
             sample_total_o};
      if (pending_res.size() == 0) begin
        if (errs < 10) $display("unexpected result: %s", fmt_res(got));
        errs++;
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          if (errs < 10) begin
            $display("result mismatch at cycle %0d", cycles);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(got));
          end
          errs++;
        end
      end
    end
  end

  // a fully random transaction
  function automatic probe_txn_t noise();
    probe_txn_t t;
    t.op       = 2'($urandom);
    t.passed   = 1'($urandom);
    t.matched  = 1'($urandom);
    t.rtt      = 20'($urandom);
    t.deferred = 1'($urandom);
    t.blocked  = 1'($urandom);
    return t;
  endfunction

  // a counted probe meant to come out ok or failed under the present registers
  function automatic probe_txn_t make_probe(bit want_ok);
    probe_txn_t  t;
    int unsigned lim16;
    lim16      = {cfg.latency_limit_ms, 4'h0};
    t.op       = OP_PROBE;
    t.deferred = 1'b0;
    t.blocked  = 1'($urandom);
    t.passed   = 1'b1;
    t.matched  = 1'($urandom);
    case ($urandom_range(5))
      0: t.rtt = 20'($urandom);
      1: t.rtt = 20'($urandom_range(4095));
      // just either side of the half-ms rounding point
      2: t.rtt = {16'($urandom), ($urandom_range(1) ? 4'h8 : 4'h7)};
      // around the latency limit
      3: t.rtt = (lim16 == 0) ? 20'hFFFFF : 20'(lim16 + $urandom_range(2) - 1);
      4: t.rtt = $urandom_range(1) ? 20'hFFFFF : 20'h0;
      default: t.rtt = (lim16 == 0) ? 20'($urandom) : 20'($urandom_range(lim16));
    endcase
    if (want_ok) begin
      if (cfg.dns_check_enable) t.matched = 1'b1;
      if (lim16 != 0 && t.rtt > lim16) t.rtt = 20'($urandom_range(lim16));
    end else begin
      case ($urandom_range(2))
        0: t.passed = 1'b0;
        1: begin
          if (cfg.dns_check_enable) t.matched = 1'b0;
          else t.passed = 1'b0;
        end
        default: begin
          // passed, but over the limit
          if (lim16 != 0 && lim16 < 20'hFFFFF) t.rtt = 20'($urandom_range(20'hFFFFF, lim16 + 1));
          else t.passed = 1'b0;
        end
      endcase
    end
    return t;
  endfunction

  // offers one transaction, predicts its result once accepted
  task automatic offer(input probe_txn_t t, input bit typed, input health_res_t typed_res);
    health_res_t pred;
    while (!steady && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    opcode_i         <= t.op;
    probe_passed_i   <= t.passed;
    answer_matched_i <= t.matched;
    rtt_sixteenths_i <= t.rtt;
    was_deferred_i   <= t.deferred;
    target_blocked_i <= t.blocked;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_monitor(t);
    pending_res.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  // one apb transfer; read data is taken in the access cycle
  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_and_check(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    apb_xfer(1'b0, idx, 32'h0, rd);
    if (rd !== value) begin
      if (errs < 10) $display("register %0d reads 0x%08h, expected 0x%08h", idx, rd, value);
      errs++;
    end
  endtask

  // registers are only touched once the block has handed over every result
  task automatic program_monitor(input int unsigned fth, input int unsigned oth,
                                 input int unsigned lim, input int unsigned dns);
    wait_drained();
    cfg.fail_threshold   = 8'(fth);
    cfg.ok_threshold     = 8'(oth);
    cfg.latency_limit_ms = 16'(lim);
    cfg.dns_check_enable = 1'(dns);
    write_and_check(REG_FAIL_TH, 32'(cfg.fail_threshold));
    write_and_check(REG_OK_TH,   32'(cfg.ok_threshold));
    write_and_check(REG_LAT_LIM, 32'(cfg.latency_limit_ms));
    write_and_check(REG_DNS_EN,  32'(cfg.dns_check_enable));
  endtask

  // mostly runs of ok or failed probes around the thresholds, some rollups,
  // run resets, deferred and junk transactions
  task automatic run_phase(input int unsigned quota);
    int unsigned done, len, th, k;
    bit          want_ok;
    probe_txn_t  t;
    done = 0;
    while (done < quota) begin
      // now and then hold off until the block has nothing outstanding
      if ($urandom_range(39) == 0) wait_drained();
      k = $urandom_range(99);
      t = noise();
      if (k < 7) begin
        t.op = OP_ROLLUP;
        offer(t, 1'b0, '0);
        done++;
      end else if (k < 10) begin
        // deferred probes are dropped and do not count toward the quota
        t.op       = OP_PROBE;
        t.deferred = 1'b1;
        offer(t, 1'b0, '0);
      end else if (k < 12) begin
        t.op = OP_UNUSED;
        offer(t, 1'b0, '0);
      end else if (k < 14) begin
        t.op = OP_CLEAR;
        offer(t, 1'b0, '0);
        done++;
      end else if (k < 20) begin
        offer(t, 1'b0, '0);
        done++;
      end else begin
        want_ok = 1'($urandom);
        th      = want_ok ? cfg.ok_threshold : cfg.fail_threshold;
        if (th == 0) th = 1;
        len = $urandom_range(th + 2, 1);
        repeat (len) offer(make_probe(want_ok), 1'b0, '0);
        done += len;
      end
    end
    t    = noise();
    t.op = OP_ROLLUP;
    offer(t, 1'b0, '0);
  endtask

  // a result with only kind, health, round trip and re-probe set
  function automatic health_res_t plain(logic [2:0] k, logic [1:0] h, logic [19:0] rtt,
                                        logic q);
    health_res_t r;
    r          = '0;
    r.kind     = k;
    r.health   = h;
    r.last_rtt = rtt;
    r.quick    = q;
    return r;
  endfunction

  task automatic add_row(input probe_txn_t t, input bit typed, input health_res_t r);
    dir_row_t row;
    row.txn   = t;
    row.typed = typed;
    row.res   = r;
    dir_rows.push_back(row);
  endtask

  initial begin
    probe_txn_t t;

    cfg.fail_threshold   = 8'd3;
    cfg.ok_threshold     = 8'd2;
    cfg.latency_limit_ms = 16'd0;
    cfg.dns_check_enable = 1'b0;
    clear_monitor();

    // directed table, run under the reset register values
    // empty bucket on a fresh monitor
    add_row(probe_txn_t'{OP_ROLLUP, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0}, 1'b1,
            plain(KIND_EMPTY, H_UNKNOWN, 20'h0, 1'b0));
    // deferred probe is ignored
    add_row(probe_txn_t'{OP_PROBE, 1'b1, 1'b1, 20'hFFFFF, 1'b1, 1'b1}, 1'b1,
            plain(KIND_IGNORED, H_UNKNOWN, 20'h0, 1'b0));
    // unused opcode with every field set
    add_row(probe_txn_t'{OP_UNUSED, 1'b1, 1'b1, 20'hFFFFF, 1'b1, 1'b1}, 1'b1,
            plain(KIND_IGNORED, H_UNKNOWN, 20'h0, 1'b0));
    // first success: mid-transition, quick re-probe
    add_row(probe_txn_t'{OP_PROBE, 1'b1, 1'b1, 20'h0, 1'b0, 1'b0}, 1'b1,
            plain(KIND_COUNTED, H_UNKNOWN, 20'h0, 1'b1));
    // second success at the largest round trip goes up; dns off so no match needed
    add_row(probe_txn_t'{OP_PROBE, 1'b1, 1'b0, 20'hFFFFF, 1'b0, 1'b0}, 1'b1,
            plain(KIND_ALERT, H_UP, 20'hFFFFF, 1'b0));
    // rollup of 0 ms and a saturated 65535 ms
    add_row(probe_txn_t'{OP_ROLLUP, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0}, 1'b1,
            '{KIND_REPORT, H_UP, 8'd0, 1'b0, 20'hFFFFF, 1'b0, 16'd2, 16'd0,
              16'hFFFF, 16'hFFFF, 17'd2});
    // bucket was cleared by the rollup
    add_row(probe_txn_t'{OP_ROLLUP, 1'b1, 1'b1, 20'h5, 1'b0, 1'b1}, 1'b1,
            plain(KIND_EMPTY, H_UP, 20'hFFFFF, 1'b0));
    // blocked failures walk down, the third one raises the alert
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b1, 20'h00123, 1'b0, 1'b1}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b0, 20'h00008, 1'b0, 1'b1}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b1, 20'h00007, 1'b0, 1'b1}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b0, 20'h00040, 1'b0, 1'b0}, 1'b0, '0);
    // rounding: 23/16 ms to 1, 24/16 ms to 2
    add_row(probe_txn_t'{OP_PROBE, 1'b1, 1'b1, 20'h00017, 1'b0, 1'b0}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b1, 1'b0, 20'h00018, 1'b0, 1'b1}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b0, 20'h00100, 1'b1, 1'b1}, 1'b0, '0);
    add_row(probe_txn_t'{OP_ROLLUP, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b1, 20'hFFFFF, 1'b0, 1'b1}, 1'b0, '0);
    // run reset wipes everything but the registers
    add_row(probe_txn_t'{OP_CLEAR, 1'b1, 1'b1, 20'hFFFFF, 1'b1, 1'b1}, 1'b1,
            plain(KIND_COUNTED, H_UNKNOWN, 20'h0, 1'b0));
    add_row(probe_txn_t'{OP_ROLLUP, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0}, 1'b1,
            plain(KIND_EMPTY, H_UNKNOWN, 20'h0, 1'b0));
    // failures only, so the rollup has no latencies
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b0, 20'h00321, 1'b0, 1'b0}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b1, 20'h54321, 1'b0, 1'b1}, 1'b0, '0);
    add_row(probe_txn_t'{OP_PROBE, 1'b0, 1'b0, 20'hABCDE, 1'b0, 1'b0}, 1'b0, '0);
    add_row(probe_txn_t'{OP_ROLLUP, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0}, 1'b0, '0);
    add_row(probe_txn_t'{OP_CLEAR, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0}, 1'b1,
            plain(KIND_COUNTED, H_UNKNOWN, 20'h0, 1'b0));

    // reset held low from the start, released on a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].res);

    // smallest thresholds, no limit
    program_monitor(1, 1, 0, 0);
    run_phase(50);
    // moderate thresholds, 100 ms limit, dns checking on
    program_monitor(4, 3, 100, 1);
    run_phase(50);
    // long way down so the burst cap is reached, 1 ms limit
    program_monitor(12, 2, 1, 0);
    run_phase(50);
    // zero thresholds act as one, largest limit
    program_monitor(0, 0, 65535, 1);
    run_phase(40);

    // largest thresholds with no idling on either side: long streaks that stay
    // mid-transition, the latency store overflows and its rollup uses a full store
    steady = 1'b1;
    program_monitor(255, 255, 65535, 1);
    repeat (66) offer(make_probe(1'b0), 1'b0, '0);
    repeat (66) offer(make_probe(1'b1), 1'b0, '0);
    t    = noise();
    t.op = OP_ROLLUP;
    offer(t, 1'b0, '0);
    steady = 1'b0;

    program_monitor($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(65535),
                    $urandom_range(1));
    run_phase(30);
    // back to the reset values
    program_monitor(3, 2, 0, 0);
    run_phase(30);

    // drain, then leave room for any stray result
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errs == 0) begin
      $display("PASS probe_health_hysteresis_rollup_top");
    end else begin
      $display("FAIL probe_health_hysteresis_rollup_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/phr_pkg.sv
rtl/phr_ram.sv
rtl/phr_regs.sv
rtl/phr_ctrl.sv
rtl/phr_dp.sv
rtl/probe_health_hysteresis_rollup_top.sv
sim/tb.sv
